[rtl/core/prtt_pkg.sv]
// Package: shared constants, types and opcodes for the round-trip tracker.
package prtt_pkg;
	localparam int PARTICIPANTS_DEF = 16;
	localparam int PENDING_DEF      = 8;
	localparam logic [7:0]  ALPHA_RESET = 8'd32;
	localparam logic [31:0] AGE_RESET   = 32'd5000000;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_PING   = 3'd1;
	localparam logic [2:0] OP_PONG   = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_DISPL   = 2'd2;

	localparam logic CFG_ALPHA = 1'b0;
	localparam logic CFG_AGE   = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;     // latch item, clear scan
		logic scan;     // process one pending slot
		logic commit;   // write participant stats / choose slot
		logic blend;    // run one EWMA step
		logic div_start;
		logic div_step;
		logic emit;
	} prtt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic need_blend;
		logic div_done;
	} prtt_sts_t;
endpackage

[rtl/core/prtt_ctrl.sv]
// Controller: sequences scan, update, blend, divide and result strobe.
module prtt_ctrl import prtt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  prtt_sts_t sts,
	output prtt_cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_COMMIT = 7'b0000100,
		S_BLEND  = 7'b0001000,
		S_DIVST  = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (start) begin
				cmd.load = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_BLEND;
			end
			S_BLEND: begin
				cmd.blend = sts.need_blend;
				state_d = S_DIVST;
			end
			S_DIVST: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE) else $error("emit not followed by idle");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == S_SCAN) else $error("start lost");
endmodule

[rtl/core/prtt_dp.sv]
// Datapath: pending table, participant statistics, EWMA and loss divider.
module prtt_dp import prtt_pkg::*; #(
	parameter int PARTICIPANTS = PARTICIPANTS_DEF,
	parameter int PENDING      = PENDING_DEF,
	localparam int PW = (PARTICIPANTS > 1) ? $clog2(PARTICIPANTS) : 1,
	localparam int SW = (PENDING > 1) ? $clog2(PENDING) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  prtt_cmd_t   cmd,
	output prtt_sts_t   sts,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  opcode,
	input  logic [3:0]  participant,
	input  logic [31:0] ping_id,
	output logic [1:0]  status,
	output logic [31:0] rtt_ticks,
	output logic [39:0] rtt_avg_q8,
	output logic [39:0] jitter_avg_q8,
	output logic [31:0] sent_count,
	output logic [31:0] recv_count,
	output logic [14:0] loss_pct_q8
);
	localparam int SLOTS = PARTICIPANTS * PENDING;

	logic [7:0]  alpha_q;
	logic [31:0] age_q, time_q;
	logic [39:0] rtt_avg_q [PARTICIPANTS];
	logic [39:0] jit_avg_q [PARTICIPANTS];
	logic [31:0] sent_q [PARTICIPANTS];
	logic [31:0] recv_q [PARTICIPANTS];
	logic [SLOTS-1:0] pvalid_q;

	// pending id and time share one table with a registered read port
	logic [63:0] pmem_q [SLOTS];
	logic [63:0] prd_q;
	logic        mem_we;

	logic [2:0]  op_q;
	logic [PW-1:0] p_q;
	logic        pin_q; // participant in range
	logic [31:0] id_q;
	logic [SW:0] cnt_q;
	logic        hit_q, free_q;
	logic [SW-1:0] hit_slot_q, free_slot_q, old_slot_q;
	logic [31:0] old_age_q, hit_age_q;
	logic [PENDING-1:0] stale_q;
	logic        blend_q;
	logic [39:0] r_q;

	logic [SW-1:0] slot, prev_slot;
	logic [PW+SW-1:0] gidx, base, raddr;
	logic [31:0] age;
	assign slot = cnt_q[SW-1:0];
	assign prev_slot = slot - SW'(1);
	assign base = (PW+SW)'(p_q) * (PW+SW)'(PENDING);
	assign raddr = base + (PW+SW)'(slot);
	// read data in prd_q belongs to the slot addressed in the previous cycle
	assign gidx = base + (PW+SW)'(prev_slot);
	assign age  = time_q - prd_q[31:0];

	// divider state
	logic [46:0] rem_q;
	logic [14:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  dcnt_q;
	logic [46:0] num;

	assign sts = '{scan_last: (cnt_q == (SW+1)'(PENDING)),
	               need_blend: blend_q,
	               div_done: (dcnt_q == 5'd0)};

	logic [PW+SW-1:0] pick;

	// EWMA step
	logic [39:0] ra, ja, dd;
	logic [49:0] rb, jb;
	logic [8:0]  am;
	assign ra = rtt_avg_q[p_q];
	assign ja = jit_avg_q[p_q];
	assign dd = (r_q > ra) ? r_q - ra : ra - r_q;
	assign am = 9'd256 - {1'b0, alpha_q};
	assign rb = ({10'd0, ra} * 50'(am) + {10'd0, r_q} * 50'(alpha_q) + 50'd128) >> 8;
	assign jb = ({10'd0, ja} * 50'(am) + {10'd0, dd} * 50'(alpha_q) + 50'd128) >> 8;

	always_comb begin
		if (hit_q) pick = base + (PW+SW)'(hit_slot_q);
		else if (free_q) pick = base + (PW+SW)'(free_slot_q);
		else pick = base + (PW+SW)'(old_slot_q);
	end

	assign mem_we = cmd.commit && pin_q && (op_q == OP_PING);

	always_ff @(posedge clk) begin
		if (mem_we) pmem_q[pick] <= {id_q, time_q};
		prd_q <= pmem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			age_q   <= AGE_RESET;
			time_q  <= '0;
			pvalid_q <= '0;
			for (int i = 0; i < PARTICIPANTS; i++) begin
				rtt_avg_q[i] <= '0;
				jit_avg_q[i] <= '0;
				sent_q[i] <= '0;
				recv_q[i] <= '0;
			end
			status <= '0;
			rtt_ticks <= '0;
			rtt_avg_q8 <= '0;
			jitter_avg_q8 <= '0;
			sent_count <= '0;
			recv_count <= '0;
			loss_pct_q8 <= '0;
			dcnt_q <= '0;
			blend_q <= 1'b0;
			op_q <= OP_TICK;
			p_q <= '0;
			pin_q <= 1'b0;
			id_q <= '0;
			cnt_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_slot_q <= '0;
			free_slot_q <= '0;
			old_slot_q <= '0;
			old_age_q <= '0;
			hit_age_q <= '0;
			stale_q <= '0;
			r_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_ALPHA) alpha_q <= cfg_data[7:0];
				else age_q <= cfg_data;
			end
			if (cmd.load) begin
				op_q  <= opcode;
				p_q   <= PW'(participant);
				pin_q <= (32'(participant) < PARTICIPANTS);
				id_q  <= ping_id;
				cnt_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				hit_slot_q <= '0;
				free_slot_q <= '0;
				old_slot_q <= '0;
				old_age_q <= '0;
				hit_age_q <= '0;
				stale_q <= '0;
				blend_q <= 1'b0;
				if (opcode == OP_TICK) time_q <= time_q + 32'd1;
			end
			if (cmd.scan) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q != '0) begin
					if (!hit_q && pvalid_q[gidx] && prd_q[63:32] == id_q) begin
						hit_q <= 1'b1;
						hit_slot_q <= prev_slot;
						hit_age_q <= age;
					end
					if (!free_q && !pvalid_q[gidx]) begin
						free_q <= 1'b1;
						free_slot_q <= prev_slot;
					end
					if (cnt_q == (SW+1)'(1) || age > old_age_q) begin
						old_age_q <= age;
						old_slot_q <= prev_slot;
					end
					stale_q[prev_slot] <= pvalid_q[gidx] && (age > age_q);
				end
			end
			if (cmd.commit) begin
				status <= ST_OK;
				rtt_ticks <= '0;
				if (!pin_q || op_q > OP_REMOVE || op_q == OP_TICK) begin
					if (pin_q == 1'b0 && op_q == OP_PONG) status <= ST_NOMATCH;
				end else if (op_q == OP_PING) begin
					pvalid_q[pick] <= 1'b1;
					if (!hit_q && !free_q) status <= ST_DISPL;
					if (sent_q[p_q] != '1) sent_q[p_q] <= sent_q[p_q] + 32'd1;
				end else if (op_q == OP_PONG) begin
					if (!hit_q) status <= ST_NOMATCH;
					else begin
						rtt_ticks <= hit_age_q;
						if (recv_q[p_q] != '1) recv_q[p_q] <= recv_q[p_q] + 32'd1;
						// drop the matched entry and every entry of this participant past the age limit
						for (int i = 0; i < PENDING; i++) begin
							if (SW'(i) == hit_slot_q || stale_q[i])
								pvalid_q[base + (PW+SW)'(i)] <= 1'b0;
						end
						r_q <= {hit_age_q, 8'd0};
						if (rtt_avg_q[p_q] == '0) rtt_avg_q[p_q] <= {hit_age_q, 8'd0};
						else blend_q <= 1'b1;
					end
				end else if (op_q == OP_REMOVE) begin
					rtt_avg_q[p_q] <= '0;
					jit_avg_q[p_q] <= '0;
					sent_q[p_q] <= '0;
					recv_q[p_q] <= '0;
					for (int i = 0; i < PENDING; i++)
						pvalid_q[base + (PW+SW)'(i)] <= 1'b0;
				end
			end
			if (cmd.blend) begin
				rtt_avg_q[p_q] <= rb[39:0];
				jit_avg_q[p_q] <= jb[39:0];
			end
			if (cmd.div_start) begin
				// numerator 25600*(s-r) + s/2, restoring division 15 bits
				rem_q <= 47'(sent_q[p_q] - recv_q[p_q]) * 47'd25600
				       + 47'(sent_q[p_q] >> 1);
				dvs_q <= sent_q[p_q];
				quo_q <= '0;
				dcnt_q <= 5'd15;
			end
			if (cmd.div_step && dcnt_q != 5'd0) begin
				dcnt_q <= dcnt_q - 5'd1;
				if (num >= ({15'd0, dvs_q} << (dcnt_q - 5'd1))) begin
					rem_q <= num - ({15'd0, dvs_q} << (dcnt_q - 5'd1));
					quo_q <= {quo_q[13:0], 1'b1};
				end else quo_q <= {quo_q[13:0], 1'b0};
			end
			if (cmd.emit) begin
				if (pin_q && op_q != OP_TICK && op_q <= OP_REMOVE) begin
					rtt_avg_q8 <= rtt_avg_q[p_q];
					jitter_avg_q8 <= jit_avg_q[p_q];
					sent_count <= sent_q[p_q];
					recv_count <= recv_q[p_q];
					loss_pct_q8 <= (sent_q[p_q] != '0 && recv_q[p_q] < sent_q[p_q]) ?
						quo_q : 15'd0;
				end else begin
					rtt_avg_q8 <= '0;
					jitter_avg_q8 <= '0;
					sent_count <= '0;
					recv_count <= '0;
					loss_pct_q8 <= '0;
				end
			end
		end
	end
	assign num = rem_q;
endmodule

[rtl/core/ping_rtt_jitter_tracker.sv]
// Top level: round-trip and jitter tracker, controller plus datapath.
// An item is taken when start is high and busy low; busy then stays high while
// the controller steps through a scan of every pending slot plus the registered
// table read, a commit, an EWMA blend, a divider load and the bit-serial loss
// divider, then a step that registers the result. The single result appears for
// one cycle with done high right after busy drops, and a new item can be taken
// as soon as busy is low. The receiver cannot stall; results must be taken when
// done is high.
module ping_rtt_jitter_tracker import prtt_pkg::*; #(
	parameter int PARTICIPANTS = PARTICIPANTS_DEF,
	parameter int PENDING_PER_PARTICIPANT = PENDING_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  opcode,
	input  logic [3:0]  participant,
	input  logic [31:0] ping_id,
	output logic [1:0]  status,
	output logic [31:0] rtt_ticks,
	output logic [39:0] rtt_avg_q8,
	output logic [39:0] jitter_avg_q8,
	output logic [31:0] sent_count,
	output logic [31:0] recv_count,
	output logic [14:0] loss_pct_q8
);
	prtt_cmd_t cmd;
	prtt_sts_t sts;
	logic emit_q;

	assign cfg_ready = 1'b1;

	prtt_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .cmd);

	prtt_dp #(.PARTICIPANTS(PARTICIPANTS), .PENDING(PENDING_PER_PARTICIPANT)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_valid, .cfg_index, .cfg_data,
		.opcode, .participant, .ping_id, .status, .rtt_ticks, .rtt_avg_q8,
		.jitter_avg_q8, .sent_count, .recv_count, .loss_pct_q8
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_q <= 1'b0;
		else emit_q <= cmd.emit;
	end
	assign done = emit_q;
endmodule
